>>> src/tdbsc_pkg.sv
// Shared types and constants for the looping-tape drive controller.
// No dependencies; imported by tape_drive_byte_stream_controller.
package tdbsc_pkg;

    // geometry
    localparam int WINDOW_BYTES = 8;
    localparam int TAPE_BYTES   = 131072;
    localparam int DRIVE_COUNT  = 8;

    localparam int DRIVE_W  = $clog2(DRIVE_COUNT);
    localparam int POS_W    = $clog2(TAPE_BYTES);
    localparam int ADDR_W   = DRIVE_W + POS_W;
    localparam int MEM_DEPTH = DRIVE_COUNT * TAPE_BYTES;

    // field and register widths
    localparam int SEL_W    = 4;
    localparam int NUMD_W   = 4;
    localparam int TLEN_W   = 18;
    localparam int PERIOD_W = 10;
    localparam int CFG_W    = 18;
    localparam int TIMER_W  = 32;
    localparam int CNT_W    = (POS_W + 1 > TLEN_W) ? POS_W + 1 : TLEN_W;

    localparam logic [SEL_W-1:0]    NO_DRIVE          = SEL_W'(8);
    localparam logic [TLEN_W-1:0]   TAPE_LENGTH_RESET = TLEN_W'(131072);
    localparam logic [PERIOD_W-1:0] BYTE_PERIOD_RESET = PERIOD_W'(265);
    localparam logic [TIMER_W-1:0]  TIMER_FLOOR       = 32'h8000_0000;

    // status byte bits
    localparam logic [7:0] STATUS_BASE     = 8'hE9;
    localparam logic [7:0] STATUS_NO_DRIVE = 8'h06;
    localparam logic [7:0] STATUS_GAP      = 8'h04;
    localparam logic [7:0] STATUS_SYNC     = 8'h02;
    localparam logic [7:0] SYNC_BYTE       = 8'hFF;

    typedef enum logic [2:0] {
        OP_CTRL_WR   = 3'd0,
        OP_DATA_WR   = 3'd1,
        OP_DATA_RD   = 3'd2,
        OP_STATUS_RD = 3'd3,
        OP_TICK      = 3'd4,
        OP_LOAD      = 3'd5,
        OP_PEEK      = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        CFG_NUM_DRIVES   = 2'd0,
        CFG_DRIVE_PRESENT = 2'd1,
        CFG_TAPE_LENGTH  = 2'd2,
        CFG_BYTE_PERIOD  = 2'd3
    } cfg_idx_t;

    // request held between the memory access and the result stage
    typedef struct packed {
        op_t              op;
        logic             moved;
        logic             from_mem;
        logic [7:0]       tick_byte;
        logic             peek_ok;
        logic [SEL_W-1:0] drive;
        logic [7:0]       written;
    } stage_t;

endpackage

>>> src/tape_drive_byte_stream_controller.sv
// Looping-tape drive controller: drive select, byte timer, tape memory, byte window.
// Depends on tdbsc_pkg.
//
// One request per cycle is sustained unless out_ready stalls; each passes the middle
// stage and the result registers. The tape data lives in a single-port synchronous
// memory (one byte per drive and tape position) that each request touches at most
// once: a tick writes the pending byte or reads the byte under the head, a load
// writes, a peek reads. Drive select, byte timer and head positions update at accept;
// byte window, gap and sync flags update as the request advances. Tape contents are
// undefined until loaded or written; there is no clearing pass after reset.
module tape_drive_byte_stream_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [tdbsc_pkg::CFG_W-1:0]   cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    opcode,
    input  logic [7:0]                    data,
    input  logic [16:0]                   cycle_stamp,
    input  logic [15:0]                   elapsed,
    input  logic [2:0]                    load_drive,
    input  logic [16:0]                   load_address,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    read_data,
    output logic [tdbsc_pkg::SEL_W-1:0]   selected_drive,
    output logic                          gap_seen,
    output logic                          sync_seen,
    output logic [7:0]                    changed_drives
);
    import tdbsc_pkg::*;

    // configuration registers
    logic [NUMD_W-1:0]   num_drives_reg;
    logic [7:0]          drive_present_reg;
    logic [TLEN_W-1:0]   tape_length_reg;
    logic [PERIOD_W-1:0] byte_period_reg;

    // controller state
    logic [7:0]          select_map_reg, select_map_next;
    logic                comms_level_reg, comms_level_next;
    logic [SEL_W-1:0]    current_drive_reg, current_drive_next;
    logic                write_enable_reg, write_enable_next;
    logic [7:0]          pending_byte_reg, pending_byte_next;
    logic [TIMER_W-1:0]  byte_timer_reg, byte_timer_next;
    logic [7:0]          written_mask_reg, written_mask_next;
    logic [POS_W-1:0]    head_pos_reg [DRIVE_COUNT];
    logic                head_we;
    logic [POS_W-1:0]    head_wdata;

    // byte window and flags
    logic [7:0]          window_reg [WINDOW_BYTES];
    logic                gap_reg, gap_next;
    logic                sync_reg, sync_next;
    logic [7:0]          new_byte;

    // tape memory
    logic [7:0]          tape_mem [MEM_DEPTH];
    logic [7:0]          mem_rdata_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [7:0]          mem_wdata;

    // pipeline
    logic                p_valid_reg;
    stage_t              p_reg, p_next;
    logic                advance, accept;
    logic                o_valid_reg;
    logic [7:0]          o_read_data_reg, o_read_data_next;
    logic [SEL_W-1:0]    o_drive_reg;
    logic                o_gap_reg, o_sync_reg;
    logic [7:0]          o_written_reg;

    // control write helpers
    logic [7:0]          inv_map;
    logic [DRIVE_W-1:0]  found;
    logic                found_ok;
    // tick helpers
    logic [TIMER_W:0]    timer_diff;
    logic [TIMER_W-1:0]  timer_sat;
    logic [DRIVE_W-1:0]  cur_idx;
    logic [POS_W-1:0]    tick_pos;
    logic [TLEN_W-1:0]   len_eff;
    logic [CNT_W-1:0]    pos_inc;
    op_t                 in_op;

    function automatic logic drive_ready(input logic [SEL_W-1:0] d, input logic [7:0] present);
        logic [DRIVE_W-1:0] idx;
        idx = d[DRIVE_W-1:0];
        return (d < SEL_W'(DRIVE_COUNT)) && present[idx];
    endfunction

    // handshake
    assign cfg_ready = 1'b1;
    assign advance   = p_valid_reg && (!o_valid_reg || out_ready);
    assign in_ready  = !p_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign in_op     = op_t'(opcode);
    assign cur_idx   = current_drive_reg[DRIVE_W-1:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_drives_reg    <= '0;
            drive_present_reg <= '0;
            tape_length_reg   <= TAPE_LENGTH_RESET;
            byte_period_reg   <= BYTE_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_DRIVES:    num_drives_reg    <= cfg_data[NUMD_W-1:0];
                CFG_DRIVE_PRESENT: drive_present_reg <= cfg_data[7:0];
                CFG_TAPE_LENGTH:   tape_length_reg   <= cfg_data[TLEN_W-1:0];
                CFG_BYTE_PERIOD:   byte_period_reg   <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // drive select decode from the shifted map
    always_comb
    begin
        select_map_next = {select_map_reg[6:0], data[0]};
        inv_map         = ~select_map_next;
        found           = '0;
        for (int d = 0; d < 8; d++)
        begin
            if (inv_map[d])
                found = DRIVE_W'(d);
        end
        found_ok = (inv_map != 8'h00) && ((inv_map & (inv_map - 8'd1)) == 8'h00);
    end

    // timer countdown with floor
    always_comb
    begin
        timer_diff = {byte_timer_reg[TIMER_W-1], byte_timer_reg} - (TIMER_W+1)'(elapsed);
        if (timer_diff[TIMER_W] && !timer_diff[TIMER_W-1])
            timer_sat = TIMER_FLOOR;
        else
            timer_sat = timer_diff[TIMER_W-1:0];
        tick_pos = (head_pos_reg[cur_idx] >= POS_W'(TAPE_BYTES - 1) + POS_W'(1) &&
                    POS_W'(TAPE_BYTES - 1) == {POS_W{1'b1}} ? 1'b0 : 1'b0)
                   ? '0 : head_pos_reg[cur_idx];
        len_eff  = (tape_length_reg < TLEN_W'(TAPE_BYTES)) ? tape_length_reg
                                                           : TLEN_W'(TAPE_BYTES);
        pos_inc  = CNT_W'(tick_pos) + CNT_W'(1);
    end

    // request decode: state updates and memory access at accept
    always_comb
    begin
        comms_level_next   = comms_level_reg;
        current_drive_next = current_drive_reg;
        write_enable_next  = write_enable_reg;
        pending_byte_next  = pending_byte_reg;
        byte_timer_next    = byte_timer_reg;
        written_mask_next  = written_mask_reg;
        head_we            = 1'b0;
        head_wdata         = '0;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_addr           = '0;
        mem_wdata          = pending_byte_reg;
        p_next             = '0;
        p_next.op          = in_op;
        if (accept)
        begin
            unique case (in_op)
                OP_CTRL_WR:
                begin
                    if (data[1] != comms_level_reg)
                    begin
                        if (!data[1])
                        begin
                            if (found_ok && drive_present_reg[found] &&
                                NUMD_W'(found) < num_drives_reg)
                                current_drive_next = SEL_W'(found);
                            else
                                current_drive_next = NO_DRIVE;
                        end
                        comms_level_next = data[1];
                    end
                    write_enable_next = !data[2];
                end
                OP_DATA_WR:
                begin
                    pending_byte_next = data;
                    byte_timer_next   = TIMER_W'(cycle_stamp);
                end
                OP_DATA_RD:
                begin
                    byte_timer_next = TIMER_W'(cycle_stamp);
                end
                OP_TICK:
                begin
                    if (drive_ready(current_drive_reg, drive_present_reg))
                    begin
                        if (!timer_sat[TIMER_W-1])
                            byte_timer_next = timer_sat;
                        else
                        begin
                            byte_timer_next = timer_sat + TIMER_W'(byte_period_reg);
                            p_next.moved    = 1'b1;
                            mem_addr        = {cur_idx, tick_pos};
                            if (write_enable_reg)
                            begin
                                mem_we            = 1'b1;
                                mem_wdata         = pending_byte_reg;
                                p_next.tick_byte  = pending_byte_reg;
                                pending_byte_next = 8'h00;
                                written_mask_next = written_mask_reg | (8'h01 << cur_idx);
                            end
                            else
                            begin
                                mem_re          = 1'b1;
                                p_next.from_mem = 1'b1;
                            end
                            head_we = 1'b1;
                            if (pos_inc >= CNT_W'(len_eff))
                                head_wdata = '0;
                            else
                                head_wdata = pos_inc[POS_W-1:0];
                        end
                    end
                end
                OP_LOAD:
                begin
                    if (CNT_W'(load_drive) < CNT_W'(DRIVE_COUNT) &&
                        CNT_W'(load_address) < CNT_W'(TAPE_BYTES))
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = {load_drive[DRIVE_W-1:0], load_address[POS_W-1:0]};
                        mem_wdata = data;
                    end
                end
                OP_PEEK:
                begin
                    if (CNT_W'(load_drive) < CNT_W'(DRIVE_COUNT) &&
                        CNT_W'(load_address) < CNT_W'(TAPE_BYTES))
                    begin
                        mem_re         = 1'b1;
                        mem_addr       = {load_drive[DRIVE_W-1:0], load_address[POS_W-1:0]};
                        p_next.peek_ok = 1'b1;
                    end
                end
                OP_STATUS_RD, OP_NOP: ;
                default: ;
            endcase
        end
        p_next.drive   = current_drive_next;
        p_next.written = written_mask_next;
    end

    // controller state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_map_reg    <= '0;
            comms_level_reg   <= 1'b0;
            current_drive_reg <= NO_DRIVE;
            write_enable_reg  <= 1'b0;
            pending_byte_reg  <= '0;
            byte_timer_reg    <= '0;
            written_mask_reg  <= '0;
            for (int i = 0; i < DRIVE_COUNT; i++)
                head_pos_reg[i] <= '0;
        end
        else
        begin
            if (accept && in_op == OP_CTRL_WR && data[1] != comms_level_reg && !data[1])
                select_map_reg <= select_map_next;
            comms_level_reg   <= comms_level_next;
            current_drive_reg <= current_drive_next;
            write_enable_reg  <= write_enable_next;
            pending_byte_reg  <= pending_byte_next;
            byte_timer_reg    <= byte_timer_next;
            written_mask_reg  <= written_mask_next;
            if (head_we)
                head_pos_reg[cur_idx] <= head_wdata;
        end
    end

    // tape memory, one access per request
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tape_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= tape_mem[mem_addr];
    end

    // window update and flags for a moved byte
    always_comb
    begin
        new_byte  = p_reg.from_mem ? mem_rdata_reg : p_reg.tick_byte;
        gap_next  = gap_reg;
        sync_next = sync_reg;
        if (p_reg.moved)
        begin
            gap_next = (new_byte == 8'h00);
            for (int i = 0; i < WINDOW_BYTES - 1; i++)
            begin
                if (window_reg[i] != 8'h00)
                    gap_next = 1'b0;
            end
            if (gap_next != gap_reg && new_byte == SYNC_BYTE)
                sync_next = 1'b1;
            if (sync_next && new_byte == SYNC_BYTE && window_reg[0] == SYNC_BYTE)
                sync_next = 1'b0;
        end
    end

    // read data of the result
    always_comb
    begin
        o_read_data_next = 8'h00;
        case (p_reg.op)
            OP_DATA_RD:
                o_read_data_next = window_reg[0];
            OP_STATUS_RD:
            begin
                o_read_data_next = STATUS_BASE;
                if (!drive_ready(p_reg.drive, drive_present_reg))
                    o_read_data_next = o_read_data_next | STATUS_NO_DRIVE;
                if (gap_reg)
                    o_read_data_next = o_read_data_next | STATUS_GAP;
                if (sync_reg)
                    o_read_data_next = o_read_data_next | STATUS_SYNC;
            end
            OP_PEEK:
                o_read_data_next = p_reg.peek_ok ? mem_rdata_reg : 8'h00;
            default:
                o_read_data_next = 8'h00;
        endcase
    end

    // pipeline control and window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            gap_reg     <= 1'b0;
            sync_reg    <= 1'b0;
            for (int i = 0; i < WINDOW_BYTES; i++)
                window_reg[i] <= '0;
        end
        else
        begin
            if (accept)
                p_valid_reg <= 1'b1;
            else if (advance)
                p_valid_reg <= 1'b0;
            if (advance)
                o_valid_reg <= 1'b1;
            else if (out_ready)
                o_valid_reg <= 1'b0;
            if (advance)
            begin
                gap_reg  <= gap_next;
                sync_reg <= sync_next;
                if (p_reg.moved)
                begin
                    window_reg[0] <= new_byte;
                    for (int i = 1; i < WINDOW_BYTES; i++)
                        window_reg[i] <= window_reg[i-1];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            p_reg <= p_next;
        if (advance)
        begin
            o_read_data_reg <= o_read_data_next;
            o_drive_reg     <= p_reg.drive;
            o_gap_reg       <= gap_next;
            o_sync_reg      <= sync_next;
            o_written_reg   <= p_reg.written;
        end
    end

    assign out_valid      = o_valid_reg;
    assign read_data      = o_read_data_reg;
    assign selected_drive = o_drive_reg;
    assign gap_seen       = o_gap_reg;
    assign sync_seen      = o_sync_reg;
    assign changed_drives = o_written_reg;

`ifndef NO_ASSERTIONS
    // a tape access is either a read or a write, never both
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("tape memory read and write in the same cycle");

    // an accepted request always lands in the middle stage
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> p_valid_reg)
        else $error("accepted request lost before the result stage");

    // a stalled result keeps the middle stage occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && o_valid_reg && !out_ready) |=> p_valid_reg)
        else $error("middle stage dropped while the result was stalled");

    // a head position only moves when a tick moved a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        head_we |-> (accept && in_op == OP_TICK && p_next.moved))
        else $error("head position written outside a byte move");
`endif

endmodule
